### rtl/inode_table_alloc_compact_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the file-entry table core
// Each macro expands to one labeled concurrent assertion on clk, with the
// check switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INODE_TABLE_ALLOC_COMPACT_CORE_ASSERT_SVH
`define INODE_TABLE_ALLOC_COMPACT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/itac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itac_pkg
// Types, codes and default sizes shared by the file-entry table core.
// ----------------------------------------------------------------------------
package itac_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int BLOCK_BYTES_DEF = 256;
    localparam int DATA_START_DEF  = 4096;

    // Remainder width of the block-size divider; wide enough for block sizes below 2^17 bytes.
    localparam int DIV_REM_W = 17;

    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  slot;
        logic [31:0] file_size;
        logic [31:0] start_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_used;
        logic [4:0]  file_count;
        logic [23:0] blocks_in_use;
        logic [31:0] free_pointer;
    } rsp_t;

    // One table entry as stored in the entry memory.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic [23:0] blocks;
    } entry_t;

    typedef struct packed {
        logic                 done;
        logic [31:0]          quot;
        logic [DIV_REM_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SIZE,
        ST_DIV_END,
        ST_WRITE,
        ST_RD_SLOT,
        ST_DIV_START,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

### rtl/inode_table_alloc_compact_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inode_table_alloc_compact_core
// Create: if nothing is stored, the result beat follows accept; else the
// divider gives the block count (and the aligned end if the free pointer
// advances) before the write. Delete: an empty slot goes straight to the
// result; else later entries shift down one per cycle, or the last entry's
// start sets the aligned free pointer. Busy is high through the result
// beat, then frees up. Reset empties the table and needs no clearing pass.
// ----------------------------------------------------------------------------
module inode_table_alloc_compact_core #(
    parameter int TABLE_DEPTH = itac_pkg::TABLE_DEPTH_DEF,
    parameter int BLOCK_BYTES = itac_pkg::BLOCK_BYTES_DEF,
    parameter int DATA_START  = itac_pkg::DATA_START_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire itac_pkg::req_t req,
    output logic                done,
    output itac_pkg::rsp_t      rsp
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = $bits(itac_pkg::entry_t);

    // The table is always packed: slots below occ_reg hold files, all others
    // are empty. A create takes slot occ_reg and a delete closes the gap by
    // moving every later entry down one slot, so the fill count alone tells
    // which slots are empty and the memory needs no reset.

    itac_pkg::state_t   state_reg;
    itac_pkg::state_t   state_next;
    logic [CNT_W-1:0]   occ_reg;
    logic [4:0]         files_reg;
    logic [23:0]        blocks_reg;
    logic [31:0]        free_reg;
    logic [ADDR_W-1:0]  ptr_reg;

    itac_pkg::req_t     req_reg;
    logic [1:0]         status_reg;
    logic [3:0]         slot_used_reg;
    logic [23:0]        blk_reg;
    logic [31:0]        base_reg;

    logic               accept;
    logic               full;
    logic               del_ok;
    logic               create_go;
    logic               free_match;
    logic               at_last;
    logic [31:0]        aligned;
    logic [itac_pkg::DIV_REM_W-1:0] gap;

    logic               div_go;
    logic [31:0]        div_dividend;
    itac_pkg::div_rsp_t div_rsp;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    itac_pkg::entry_t   rd_entry;
    itac_pkg::entry_t   new_entry;

    itac_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared divider: block count of a new file, and the remainder needed
    // to round a byte address up to the next block boundary.
    itac_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .rsp      (div_rsp)
    );

    assign rd_entry = itac_pkg::entry_t'(ram_rdata);

    assign new_entry.start  = req_reg.start_byte;
    assign new_entry.size   = req_reg.file_size;
    assign new_entry.blocks = blk_reg;

    assign accept     = start && !busy;
    assign full       = (occ_reg == CNT_W'(TABLE_DEPTH));
    assign del_ok     = (32'(req.slot) < 32'(occ_reg));
    assign create_go  = !full && (req.start_byte != '0);
    assign free_match = (free_reg == req_reg.start_byte);

    // In the slot-read cycle this tells whether the deleted entry is the
    // last one in use; during the shift it marks the final move, since the
    // fill count has been lowered by then.
    assign at_last = (CNT_W'(ptr_reg) == (occ_reg - CNT_W'(1)));

    // Round the divided address up to a block boundary, wrapping at 32 bits.
    assign gap     = itac_pkg::DIV_REM_W'(BLOCK_BYTES) - div_rsp.rem;
    assign aligned = (div_rsp.rem != '0) ? (base_reg + 32'(gap)) : base_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == itac_pkg::REQ_CREATE)
                    begin
                        state_next = create_go ? itac_pkg::ST_DIV_SIZE : itac_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = del_ok ? itac_pkg::ST_RD_SLOT : itac_pkg::ST_RESP;
                    end
                end
            end
            itac_pkg::ST_DIV_SIZE:
            begin
                if (div_rsp.done)
                begin
                    state_next = free_match ? itac_pkg::ST_DIV_END : itac_pkg::ST_WRITE;
                end
            end
            itac_pkg::ST_DIV_END:
            begin
                if (div_rsp.done)
                begin
                    state_next = itac_pkg::ST_WRITE;
                end
            end
            itac_pkg::ST_WRITE:
            begin
                state_next = itac_pkg::ST_RESP;
            end
            itac_pkg::ST_RD_SLOT:
            begin
                state_next = at_last ? itac_pkg::ST_DIV_START : itac_pkg::ST_SHIFT;
            end
            itac_pkg::ST_DIV_START:
            begin
                if (div_rsp.done)
                begin
                    state_next = itac_pkg::ST_RESP;
                end
            end
            itac_pkg::ST_SHIFT:
            begin
                if (at_last)
                begin
                    state_next = itac_pkg::ST_RESP;
                end
            end
            itac_pkg::ST_RESP:
            begin
                state_next = itac_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = itac_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and memory-control logic.
    always_comb
    begin
        busy         = (state_reg != itac_pkg::ST_IDLE);
        done         = (state_reg == itac_pkg::ST_RESP);
        div_go       = 1'b0;
        div_dividend = '0;
        ram_we       = 1'b0;
        ram_waddr    = ptr_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;
        case (state_reg)
            itac_pkg::ST_IDLE:
            begin
                // Start reading the named slot right away for a delete.
                ram_raddr    = ADDR_W'(req.slot);
                div_dividend = req.file_size;
                div_go       = accept && (req.req_type == itac_pkg::REQ_CREATE) && create_go;
            end
            itac_pkg::ST_DIV_SIZE:
            begin
                div_dividend = req_reg.start_byte + req_reg.file_size;
                div_go       = div_rsp.done && free_match;
            end
            itac_pkg::ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(occ_reg);
                ram_wdata = new_entry;
            end
            itac_pkg::ST_RD_SLOT:
            begin
                // The first shift move needs the entry just above the slot.
                ram_raddr    = ptr_reg + ADDR_W'(1);
                div_dividend = rd_entry.start;
                div_go       = at_last;
            end
            itac_pkg::ST_SHIFT:
            begin
                // Entry ptr+1 arrives now and lands at ptr; fetch ptr+2.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = ptr_reg + ADDR_W'(2);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state and the running totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itac_pkg::ST_IDLE;
            occ_reg    <= '0;
            files_reg  <= '0;
            blocks_reg <= '0;
            free_reg   <= 32'(DATA_START);
            ptr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                itac_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        ptr_reg <= ADDR_W'(req.slot);
                    end
                end
                itac_pkg::ST_DIV_END:
                begin
                    if (div_rsp.done)
                    begin
                        free_reg <= aligned;
                    end
                end
                itac_pkg::ST_WRITE:
                begin
                    occ_reg    <= occ_reg + CNT_W'(1);
                    files_reg  <= files_reg + 5'd1;
                    blocks_reg <= blocks_reg + blk_reg;
                end
                itac_pkg::ST_RD_SLOT:
                begin
                    occ_reg    <= occ_reg - CNT_W'(1);
                    files_reg  <= files_reg - 5'd1;
                    blocks_reg <= blocks_reg - rd_entry.blocks;
                end
                itac_pkg::ST_DIV_START:
                begin
                    if (div_rsp.done)
                    begin
                        free_reg <= aligned;
                    end
                end
                itac_pkg::ST_SHIFT:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(1);
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    // Request copy, result code and divider operands.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
            if (req.req_type == itac_pkg::REQ_CREATE)
            begin
                status_reg    <= full ? itac_pkg::STAT_FULL : itac_pkg::STAT_OK;
                slot_used_reg <= full ? 4'd0 : 4'(occ_reg);
            end
            else
            begin
                status_reg    <= del_ok ? itac_pkg::STAT_OK : itac_pkg::STAT_EMPTY;
                slot_used_reg <= req.slot;
            end
        end
        if (div_go)
        begin
            base_reg <= div_dividend;
        end
        if ((state_reg == itac_pkg::ST_DIV_SIZE) && div_rsp.done)
        begin
            // Block count is the quotient rounded up, kept to 24 bits.
            blk_reg <= div_rsp.quot[23:0] + 24'(div_rsp.rem != '0);
        end
    end

    assign rsp.status        = status_reg;
    assign rsp.slot_used     = slot_used_reg;
    assign rsp.file_count    = files_reg;
    assign rsp.blocks_in_use = blocks_reg;
    assign rsp.free_pointer  = free_reg;

endmodule
`default_nettype wire

### rtl/itac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itac_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module itac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/itac_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itac_div
// Divider by a constant block size using reciprocal multiplication; the
// dividend, product, estimate and corrected result are registered in turn.
// ----------------------------------------------------------------------------
module itac_div #(
    parameter int DIVISOR = itac_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire logic [31:0]        dividend,
    output itac_pkg::div_rsp_t      rsp
);

    // The quotient estimate from the truncated reciprocal of 2^32 / DIVISOR
    // is exact or one short; a final compare and subtract corrects it.
    localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(DIVISOR);
    localparam logic [31:0] RECIP      = (DIVISOR == 1) ? 32'hFFFF_FFFF : RECIP_FULL[31:0];
    localparam logic [31:0] DIV_VAL    = 32'(DIVISOR);

    logic [2:0]                     vld_reg;
    logic                           done_reg;
    logic [31:0]                    x_reg;
    logic [63:0]                    prod_reg;
    logic [31:0]                    est_reg;
    logic [31:0]                    back_reg;
    logic [31:0]                    quot_reg;
    logic [itac_pkg::DIV_REM_W-1:0] rem_reg;
    logic [31:0]                    part;
    logic                           fix;

    assign part = x_reg - back_reg;
    assign fix  = (part >= DIV_VAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], go};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            x_reg <= dividend;
        end
        if (vld_reg[0])
        begin
            prod_reg <= 64'(x_reg) * 64'(RECIP);
        end
        if (vld_reg[1])
        begin
            est_reg  <= prod_reg[63:32];
            back_reg <= prod_reg[63:32] * DIV_VAL;
        end
        if (vld_reg[2])
        begin
            quot_reg <= est_reg + 32'(fix);
            rem_reg  <= itac_pkg::DIV_REM_W'(fix ? (part - DIV_VAL) : part);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

### rtl/itac_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itac_checker
// Port-level checks of the file-entry table core, bound to the top level.
// ----------------------------------------------------------------------------
`include "inode_table_alloc_compact_core_assert.svh"

module itac_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire itac_pkg::req_t req,
    input wire logic           done,
    input wire itac_pkg::rsp_t rsp
);

    // An accepted request keeps the core busy until its result beat.
    `ITAC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request left core idle")

    // Exactly one result beat per request: the core frees up right after it.
    `ITAC_ASSERT_NXT(a_done_frees, done, !busy && !done, "core stayed busy after result")

    // A full table reports no slot.
    `ITAC_ASSERT_IMP(a_full_slot, done && (rsp.status == itac_pkg::STAT_FULL),
        rsp.slot_used == 4'd0, "full report carries a slot number")

endmodule

bind inode_table_alloc_compact_core itac_checker u_itac_checker (.*);
`default_nettype wire
